@@ hdl/cau_pkg.sv @@
// Shared types and constants for the complex arithmetic unit.
// No dependencies; every other file in hdl/ imports this package.
package cau_pkg;

	localparam int W       = 32;          // operand and result component width
	localparam int FRAC    = 16;          // fraction bits of the Q16.16 format
	localparam int PW      = 2 * W;       // full product width
	localparam int NW      = PW + 1;      // sum of two products
	localparam int RW      = 3 * W;       // divider partial remainder width
	localparam int DIV_LAT = W + 1;       // prepare stage plus one stage per quotient bit

	typedef enum logic [2:0] {
		ACT_ADD  = 3'd0,
		ACT_SUB  = 3'd1,
		ACT_MUL  = 3'd2,
		ACT_DIV  = 3'd3,
		ACT_CONJ = 3'd4
	} act_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DZ  = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	typedef struct packed {
		logic [RW-1:0] rem;
		logic [W-1:0]  q;
	} div_lane_t;

	typedef struct packed {
		logic [RW-1:0] dsh;      // divisor aligned under the top quotient bit
		div_lane_t     re;
		div_lane_t     im;
		logic          neg_re;
		logic          neg_im;
		logic          ovf_re;
		logic          ovf_im;
		logic          dz;
	} div_stage_t;

	typedef struct packed {
		logic [2:0]           act;
		logic signed [NW-1:0] re;
		logic signed [NW-1:0] im;
	} side_t;

endpackage

@@ hdl/cau_prod.sv @@
// Front of the pipeline: the six 32x32 products, then the sums that feed
// saturation and the divider. Depends on cau_pkg.
module cau_prod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_vld,
	input  logic [2:0]                    act,
	input  logic signed [cau_pkg::W-1:0]  a_re,
	input  logic signed [cau_pkg::W-1:0]  a_im,
	input  logic signed [cau_pkg::W-1:0]  b_re,
	input  logic signed [cau_pkg::W-1:0]  b_im,
	output logic                          vld_s2,
	output cau_pkg::side_t                side_s2,
	output logic signed [cau_pkg::NW-1:0] nr_s2,
	output logic signed [cau_pkg::NW-1:0] ni_s2,
	output logic [cau_pkg::PW-1:0]        d_s2
);
	import cau_pkg::*;

	logic                 vld_s1;
	logic [2:0]           act_s1;
	logic signed [W-1:0]  ar_s1, ai_s1, br_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1, p_bbr_s1, p_bbi_s1;

	logic signed [NW-1:0] mre, mim, re_c, im_c;
	logic signed [W:0]    sum_re, sum_im, dif_re, dif_im, neg_ai;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			act_s1   <= act;
			ar_s1    <= a_re;
			ai_s1    <= a_im;
			br_s1    <= b_re;
			p_rr_s1  <= PW'(a_re) * PW'(b_re);
			p_ii_s1  <= PW'(a_im) * PW'(b_im);
			p_ri_s1  <= PW'(a_re) * PW'(b_im);
			p_ir_s1  <= PW'(a_im) * PW'(b_re);
			p_bbr_s1 <= PW'(b_re) * PW'(b_re);
			p_bbi_s1 <= PW'(b_im) * PW'(b_im);
		end
	end

	// b_im reaches stage 2 through its products and through bi_s1 below; keep ai*bi etc. exact
	always_comb begin
		mre    = $signed({p_rr_s1[PW-1], p_rr_s1} - {p_ii_s1[PW-1], p_ii_s1}) >>> FRAC;
		mim    = $signed({p_ri_s1[PW-1], p_ri_s1} + {p_ir_s1[PW-1], p_ir_s1}) >>> FRAC;
		sum_re = {ar_s1[W-1], ar_s1} + {br_s1[W-1], br_s1};
		dif_re = {ar_s1[W-1], ar_s1} - {br_s1[W-1], br_s1};
		neg_ai = -{ai_s1[W-1], ai_s1};
		sum_im = '0;
		dif_im = '0;
		re_c   = '0;
		im_c   = '0;
		unique case (act_s1)
			ACT_ADD: begin
				re_c = NW'(sum_re);
				im_c = NW'(sum_im);
			end
			ACT_SUB: begin
				re_c = NW'(dif_re);
				im_c = NW'(dif_im);
			end
			ACT_MUL: begin
				re_c = mre;
				im_c = mim;
			end
			ACT_CONJ: begin
				re_c = NW'(ar_s1);
				im_c = NW'(neg_ai);
			end
			default: begin
				re_c = '0;
				im_c = '0;
			end
		endcase
	end

	// imaginary add/sub need a_im and b_im: rebuild them from the first stage
	logic signed [W-1:0] ai_b_s1;
	logic signed [W:0]   aib_sum, aib_dif;
	logic signed [W-1:0] bi_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			bi_s1 <= b_im;
		end
	end

	assign ai_b_s1 = ai_s1;
	assign aib_sum = {ai_b_s1[W-1], ai_b_s1} + {bi_s1[W-1], bi_s1};
	assign aib_dif = {ai_b_s1[W-1], ai_b_s1} - {bi_s1[W-1], bi_s1};

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2.act <= act_s1;
			side_s2.re  <= re_c;
			if (act_s1 == ACT_ADD)
				side_s2.im <= NW'(aib_sum);
			else if (act_s1 == ACT_SUB)
				side_s2.im <= NW'(aib_dif);
			else
				side_s2.im <= im_c;
			nr_s2 <= {p_rr_s1[PW-1], p_rr_s1} + {p_ii_s1[PW-1], p_ii_s1};
			ni_s2 <= {p_ir_s1[PW-1], p_ir_s1} - {p_ri_s1[PW-1], p_ri_s1};
			d_s2  <= p_bbr_s1 + p_bbi_s1;
		end
	end

endmodule

@@ hdl/cau_div_step.sv @@
// One restoring division stage: retires one quotient bit for both the real
// and imaginary lanes. Depends on cau_pkg.
module cau_div_step (
	input  logic                clk,
	input  logic                en,
	input  cau_pkg::div_stage_t din,
	output cau_pkg::div_stage_t dout
);
	import cau_pkg::*;

	logic          ge_re, ge_im;
	logic [RW-1:0] r_re, r_im;
	div_stage_t    nxt;

	always_comb begin
		ge_re = din.re.rem >= din.dsh;
		ge_im = din.im.rem >= din.dsh;
		r_re  = ge_re ? din.re.rem - din.dsh : din.re.rem;
		r_im  = ge_im ? din.im.rem - din.dsh : din.im.rem;
		nxt        = din;
		nxt.re.rem = {r_re[RW-2:0], 1'b0};
		nxt.im.rem = {r_im[RW-2:0], 1'b0};
		nxt.re.q   = {din.re.q[W-2:0], ge_re};
		nxt.im.q   = {din.im.q[W-2:0], ge_im};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dout <= nxt;
		end
	end

endmodule

@@ hdl/cau_div.sv @@
// Pipelined divider for the two numerators over the shared divisor:
// a prepare stage (magnitudes, overflow, zero divisor) and W step stages.
// Depends on cau_pkg and cau_div_step.
module cau_div (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [cau_pkg::NW-1:0] nr,
	input  logic signed [cau_pkg::NW-1:0] ni,
	input  logic [cau_pkg::PW-1:0]        d,
	output cau_pkg::div_stage_t           res
);
	import cau_pkg::*;

	div_stage_t      stg [0:W];
	div_stage_t      prep_s3;
	logic [NW-1:0]   mag_re_w, mag_im_w;
	logic [PW-1:0]   mag_re, mag_im;
	logic [PW+FRAC-1:0] dlim;

	always_comb begin
		mag_re_w = nr[NW-1] ? NW'(-nr) : NW'(nr);
		mag_im_w = ni[NW-1] ? NW'(-ni) : NW'(ni);
		mag_re   = mag_re_w[PW-1:0];
		mag_im   = mag_im_w[PW-1:0];
		dlim     = {d, {FRAC{1'b0}}};
	end

	// quotient fits W bits only while |n| << FRAC stays below d << W
	always_ff @(posedge clk) begin
		if (en) begin
			prep_s3.dsh    <= {1'b0, d, {(W-1){1'b0}}};
			prep_s3.re.rem <= {{(RW-PW-FRAC){1'b0}}, mag_re, {FRAC{1'b0}}};
			prep_s3.im.rem <= {{(RW-PW-FRAC){1'b0}}, mag_im, {FRAC{1'b0}}};
			prep_s3.re.q   <= '0;
			prep_s3.im.q   <= '0;
			prep_s3.neg_re <= nr[NW-1];
			prep_s3.neg_im <= ni[NW-1];
			prep_s3.ovf_re <= {{FRAC{1'b0}}, mag_re} >= dlim;
			prep_s3.ovf_im <= {{FRAC{1'b0}}, mag_im} >= dlim;
			prep_s3.dz     <= d == '0;
		end
	end

	assign stg[0] = prep_s3;

	for (genvar k = 0; k < W; k++) begin : g_step
		cau_div_step u_step (
			.clk  (clk),
			.en   (en),
			.din  (stg[k]),
			.dout (stg[k+1])
		);
	end

	assign res = stg[W];

endmodule

@@ hdl/complex_arithmetic_unit.sv @@
// Top level of the complex arithmetic unit: product front end, divider,
// side-band delay line and the saturating output register.
// Depends on cau_pkg, cau_prod and cau_div.
//
//  channel | dir | tdata                                   | tuser
//  s_*     | in  | a_re[31:0] a_im[63:32] b_re[95:64] b_im | action[2:0]
//  m_*     | out | result_re[31:0] result_im[63:32]        | status[1:0]
//
// One transaction enters per cycle while s_tready is high; each result passes
// through the two product/sum stages, the prepare stage, the 32 quotient-bit
// stages of the divider and the output register. All operations take the
// same path. Reset clears only the valid bits. A stall on m_tready freezes the
// whole pipe at once and drops s_tready in the same cycle.
module complex_arithmetic_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // a_re, a_im, b_re, b_im
	input  logic [2:0]   s_tuser,   // action
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [63:0]  m_tdata,   // result_re, result_im
	output logic [1:0]   m_tuser    // status
);
	import cau_pkg::*;

	logic                 en;
	logic                 vld_s2;
	side_t                side_s2;
	logic signed [NW-1:0] nr_s2, ni_s2;
	logic [PW-1:0]        d_s2;
	div_stage_t           dres;

	logic                 vld_dly_q  [0:DIV_LAT-1];
	side_t                side_dly_q [0:DIV_LAT-1];

	logic                 out_vld_q;
	logic [W-1:0]         res_re_q, res_im_q;
	logic [1:0]           status_q;

	logic [W-1:0]         fre, fim;
	logic                 sat_re, sat_im;
	logic [1:0]           fst;

	assign en       = !out_vld_q || m_tready;
	assign s_tready = en;

	cau_prod u_prod (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (s_tvalid),
		.act     (s_tuser),
		.a_re    (s_tdata[31:0]),
		.a_im    (s_tdata[63:32]),
		.b_re    (s_tdata[95:64]),
		.b_im    (s_tdata[127:96]),
		.vld_s2  (vld_s2),
		.side_s2 (side_s2),
		.nr_s2   (nr_s2),
		.ni_s2   (ni_s2),
		.d_s2    (d_s2)
	);

	cau_div u_div (
		.clk (clk),
		.en  (en),
		.nr  (nr_s2),
		.ni  (ni_s2),
		.d   (d_s2),
		.res (dres)
	);

	// align the non-divide results with the divider output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_LAT; i++) vld_dly_q[i] <= 1'b0;
		end else if (en) begin
			vld_dly_q[0] <= vld_s2;
			for (int i = 1; i < DIV_LAT; i++) vld_dly_q[i] <= vld_dly_q[i-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dly_q[0] <= side_s2;
			for (int i = 1; i < DIV_LAT; i++) side_dly_q[i] <= side_dly_q[i-1];
		end
	end

	function automatic logic [W:0] clip(input logic signed [NW-1:0] v);
		logic signed [NW-1:0] hi, lo;
		hi = NW'({1'b0, {(W-1){1'b1}}});
		lo = -hi - NW'(1);
		if (v > hi)      return {1'b1, 1'b0, {(W-1){1'b1}}};
		else if (v < lo) return {1'b1, 1'b1, {(W-1){1'b0}}};
		else             return {1'b0, v[W-1:0]};
	endfunction

	function automatic logic [W:0] qfix(input logic [W-1:0] q, input logic neg,
			input logic ovf);
		logic [W-1:0] lim;
		lim = {1'b1, {(W-1){1'b0}}};
		if (neg) begin
			if (ovf || q > lim) return {1'b1, lim};
			else                return {1'b0, -q};
		end else begin
			if (ovf || q >= lim) return {1'b1, ~lim};
			else                 return {1'b0, q};
		end
	endfunction

	always_comb begin
		logic [W:0] cr, ci;
		if (side_dly_q[DIV_LAT-1].act == ACT_DIV) begin
			cr = qfix(dres.re.q, dres.neg_re, dres.ovf_re);
			ci = qfix(dres.im.q, dres.neg_im, dres.ovf_im);
		end else begin
			cr = clip(side_dly_q[DIV_LAT-1].re);
			ci = clip(side_dly_q[DIV_LAT-1].im);
		end
		sat_re = cr[W];
		sat_im = ci[W];
		fre    = cr[W-1:0];
		fim    = ci[W-1:0];
		fst    = ST_OK;
		if (side_dly_q[DIV_LAT-1].act == ACT_DIV && dres.dz) begin
			fre = '0;
			fim = '0;
			fst = ST_DZ;
		end else if (sat_re || sat_im) begin
			fst = ST_SAT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (en)
			out_vld_q <= vld_dly_q[DIV_LAT-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= fre;
			res_im_q <= fim;
			status_q <= fst;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {res_im_q, res_re_q};
	assign m_tuser  = status_q;

endmodule
